FILE: rtl/sbq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the searchable burst queue.
package sbq_pkg;

    localparam int LEN_W   = 31;
    localparam int STAMP_W = 32;
    localparam int POS_W   = 6;
    localparam int TOT_W   = 7;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    localparam int DEPTH_DEF       = 64;
    localparam int THREAD_BITS_DEF = 8;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_FIND   = 2'd2;
    localparam t_cmd CMD_REMOVE = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_RANGE     = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

endpackage

FILE: rtl/sbq_if.sv
`timescale 1ns / 1ps
// Command and result channel interfaces of the burst queue.
interface sbq_cmd_if #(
    parameter int THREAD_BITS = sbq_pkg::THREAD_BITS_DEF
);
    import sbq_pkg::*;

    logic                   valid;
    logic                   ready;
    t_cmd                   cmd;
    logic [LEN_W-1:0]       burst_length;
    logic [THREAD_BITS-1:0] thread_id;
    logic [STAMP_W-1:0]     stamp;
    logic [POS_W-1:0]       position;

    modport source (
        output valid, cmd, burst_length, thread_id, stamp, position,
        input  ready
    );
    modport sink (
        input  valid, cmd, burst_length, thread_id, stamp, position,
        output ready
    );
endinterface

interface sbq_res_if #(
    parameter int THREAD_BITS = sbq_pkg::THREAD_BITS_DEF
);
    import sbq_pkg::*;

    logic                   valid;
    logic                   ready;
    t_status                status;
    logic [POS_W-1:0]       found_position;
    logic [LEN_W-1:0]       out_length;
    logic [THREAD_BITS-1:0] out_thread;
    logic [STAMP_W-1:0]     out_stamp;
    logic [TOT_W-1:0]       entry_total;

    modport source (
        output valid, status, found_position, out_length, out_thread, out_stamp,
               entry_total,
        input  ready
    );
    modport sink (
        input  valid, status, found_position, out_length, out_thread, out_stamp,
               entry_total,
        output ready
    );
endinterface

FILE: rtl/sbq_store.sv
`timescale 1ns / 1ps
// Entry memory: one write port, one read port with registered read data.
module sbq_store #(
    parameter int DEPTH = sbq_pkg::DEPTH_DEF,
    parameter int WIDTH = 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/searchable_burst_queue_core.sv
`timescale 1ns / 1ps
// Searchable burst queue: circular entry memory with append, pop, find, remove.
//
//  channel   dir   handshake      payload
//  i_cmd     in    valid/ready    cmd, burst_length, thread_id, stamp, position
//  o_res     out   valid/ready    status, found_position, out_length, out_thread,
//                                 out_stamp, entry_total
//
// Append and any error go straight to the done state; pop and remove of the head
// first read the head entry. Find scans from the head and stops at the first match
// or at the tail. Remove at position p walks the tail down one entry per cycle
// through the single read and single write port of the memory.
// One command at a time; i_cmd.ready is high only while idle. Reset clears count
// and head; the memory is not cleared. A stalled o_res holds the next result back.
module searchable_burst_queue_core #(
    parameter int DEPTH       = sbq_pkg::DEPTH_DEF,
    parameter int THREAD_BITS = sbq_pkg::THREAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbq_cmd_if.sink   i_cmd,
    sbq_res_if.source o_res
);
    import sbq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > TOT_W) ? CNT_W : TOT_W;
    localparam int ENT_W = LEN_W + THREAD_BITS + STAMP_W;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [AW:0]      WRAP     = (AW + 1)'(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= WRAP) begin
            sum = sum - WRAP;
        end
        return sum[AW-1:0];
    endfunction

    logic [1:0]             r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [AW-1:0]          r_cur, n_cur;
    logic                   r_first, n_first;
    logic [THREAD_BITS-1:0] r_key, n_key;
    t_status                r_status, n_status;
    logic [POS_W-1:0]       r_fpos, n_fpos;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [THREAD_BITS-1:0] r_thr, n_thr;
    logic [STAMP_W-1:0]     r_stp, n_stp;

    logic                   r_out_valid, n_out_valid;
    t_status                r_o_status, n_o_status;
    logic [POS_W-1:0]       r_o_fpos, n_o_fpos;
    logic [LEN_W-1:0]       r_o_len, n_o_len;
    logic [THREAD_BITS-1:0] r_o_thr, n_o_thr;
    logic [STAMP_W-1:0]     r_o_stp, n_o_stp;
    logic [TOT_W-1:0]       r_o_total, n_o_total;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [ENT_W-1:0]       w_wdata;
    logic [AW-1:0]          w_raddr;
    logic [ENT_W-1:0]       w_rdata;
    logic [LEN_W-1:0]       w_rd_len;
    logic [THREAD_BITS-1:0] w_rd_thr;
    logic [STAMP_W-1:0]     w_rd_stp;
    logic [CNT_W-1:0]       w_cur_next;
    logic                   w_more;
    logic [EXT_W-1:0]       w_pos_ext;
    logic [EXT_W-1:0]       w_cnt_ext;
    logic [EXT_W-1:0]       w_cur_ext;

    sbq_store #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_res.ready;

    assign w_rd_len   = w_rdata[ENT_W-1 -: LEN_W];
    assign w_rd_thr   = w_rdata[STAMP_W +: THREAD_BITS];
    assign w_rd_stp   = w_rdata[STAMP_W-1:0];
    assign w_cur_next = CNT_W'(r_cur) + CNT_W'(1);
    assign w_more     = (w_cur_next < r_count);
    assign w_pos_ext  = EXT_W'(i_cmd.position);
    assign w_cnt_ext  = EXT_W'(r_count);
    assign w_cur_ext  = EXT_W'(r_cur);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_cur       = r_cur;
        n_first     = r_first;
        n_key       = r_key;
        n_status    = r_status;
        n_fpos      = r_fpos;
        n_len       = r_len;
        n_thr       = r_thr;
        n_stp       = r_stp;
        n_out_valid = r_out_valid && !o_res.ready;
        n_o_status  = r_o_status;
        n_o_fpos    = r_o_fpos;
        n_o_len     = r_o_len;
        n_o_thr     = r_o_thr;
        n_o_stp     = r_o_stp;
        n_o_total   = r_o_total;
        w_we        = 1'b0;
        w_waddr     = f_phys(r_head, r_cur - AW'(1));
        w_wdata     = w_rdata;
        w_raddr     = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_fpos   = '0;
                    n_len    = '0;
                    n_thr    = '0;
                    n_stp    = '0;
                    n_key    = i_cmd.thread_id;
                    n_first  = 1'b1;
                    n_cur    = '0;
                    n_state  = S_DONE;
                    unique case (i_cmd.cmd)
                        CMD_APPEND: begin
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_phys(r_head, w_cnt_ext[AW-1:0]);
                                w_wdata = {i_cmd.burst_length, i_cmd.thread_id, i_cmd.stamp};
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_pos_ext >= w_cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_raddr = f_phys(r_head, w_pos_ext[AW-1:0]);
                                n_cur   = w_pos_ext[AW-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT: begin
                // first beat captures the removed entry, later beats move one down
                n_first = 1'b0;
                if (r_first) begin
                    n_len = w_rd_len;
                    n_thr = w_rd_thr;
                    n_stp = w_rd_stp;
                end else begin
                    w_we = 1'b1;
                end
                if (r_first && (r_cur == '0)) begin
                    n_head  = f_phys(r_head, AW'(1));
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end else if (w_more) begin
                    w_raddr = f_phys(r_head, w_cur_next[AW-1:0]);
                    n_cur   = w_cur_next[AW-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                if (w_rd_thr == r_key) begin
                    n_fpos  = w_cur_ext[POS_W-1:0];
                    n_len   = w_rd_len;
                    n_state = S_DONE;
                end else if (w_more) begin
                    w_raddr = f_phys(r_head, w_cur_next[AW-1:0]);
                    n_cur   = w_cur_next[AW-1:0];
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_fpos    = r_fpos;
                    n_o_len     = r_len;
                    n_o_thr     = r_thr;
                    n_o_stp     = r_stp;
                    n_o_total   = w_cnt_ext[TOT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_first    <= n_first;
        r_key      <= n_key;
        r_status   <= n_status;
        r_fpos     <= n_fpos;
        r_len      <= n_len;
        r_thr      <= n_thr;
        r_stp      <= n_stp;
        r_o_status <= n_o_status;
        r_o_fpos   <= n_o_fpos;
        r_o_len    <= n_o_len;
        r_o_thr    <= n_o_thr;
        r_o_stp    <= n_o_stp;
        r_o_total  <= n_o_total;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_o_status;
    assign o_res.found_position = r_o_fpos;
    assign o_res.out_length     = r_o_len;
    assign o_res.out_thread     = r_o_thr;
    assign o_res.out_stamp      = r_o_stp;
    assign o_res.entry_total    = r_o_total;
endmodule

FILE: rtl/sbq_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the burst queue, bound to the top level.
module sbq_checker #(
    parameter int THREAD_BITS = sbq_pkg::THREAD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cmd_valid,
    input logic                           i_cmd_ready,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input sbq_pkg::t_status               i_status,
    input logic [sbq_pkg::POS_W-1:0]      i_found_position,
    input logic [sbq_pkg::LEN_W-1:0]      i_out_length,
    input logic [THREAD_BITS-1:0]         i_out_thread,
    input logic [sbq_pkg::STAMP_W-1:0]    i_out_stamp,
    input logic [sbq_pkg::TOT_W-1:0]      i_entry_total
);
    import sbq_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_status)
            && $stable(i_out_length) && $stable(i_out_thread)
            && $stable(i_out_stamp) && $stable(i_entry_total))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while previous one in flight");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == ST_NOT_FOUND) |->
            (i_found_position == '0) && (i_out_length == '0))
        else $error("failed find reports a position or length");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == ST_EMPTY) |-> (i_entry_total == '0))
        else $error("empty status with nonzero entry total");
endmodule

bind searchable_burst_queue_core sbq_checker #(
    .THREAD_BITS (THREAD_BITS)
) u_sbq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_found_position (o_res.found_position),
    .i_out_length     (o_res.out_length),
    .i_out_thread     (o_res.out_thread),
    .i_out_stamp      (o_res.out_stamp),
    .i_entry_total    (o_res.entry_total)
);
